[rtl/assert_macros.svh]
// Assertion macros, used by the sampler top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/bts_pkg.sv]
// Shared types and constants of the bilinear texel sampler.
package bts_pkg;

    localparam int SIZE_W      = 13;
    localparam int COORD_W     = 32;
    localparam int TEXEL_W     = 32;
    localparam int LANE_W      = 8;
    localparam int LANES       = 4;
    localparam int TAPS        = 4;
    localparam int WEIGHT_W    = 9;
    localparam int PRD_W       = WEIGHT_W + LANE_W;
    localparam int ACC_W       = PRD_W + 2;
    localparam int ADDR_FULL_W = 2 * SIZE_W;
    localparam int IN_ADDR_W   = 16;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_PITCH  = 2'd2;

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd256;

    typedef struct packed {
        logic valid;
        logic sample;
    } t_ctl;

    typedef logic [TEXEL_W-1:0]  t_texel;
    typedef logic [WEIGHT_W-1:0] t_weight;

    // zero size behaves as one texel
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
        return (s == '0) ? SIZE_W'(1) : s;
    endfunction

endpackage

[rtl/bts_axis.sv]
// Coordinate wrap, scale, half-texel offset and clamp for one axis (two stages).
module bts_axis import bts_pkg::*; #(
    parameter int FRAC_W = 16
) (
    input  logic                i_clk,
    input  logic [COORD_W-1:0]  i_coord,
    input  logic [SIZE_W-1:0]   i_size,
    output logic [SIZE_W-1:0]   o_idx,
    output logic [FRAC_W-1:0]   o_frac
);

    localparam int PW = FRAC_W + SIZE_W;
    localparam logic [PW-1:0] HALF = PW'(1) << (FRAC_W - 1);

    logic [SIZE_W-1:0] sz;
    logic [PW-1:0]     r_prod, n_prod;
    logic [PW-1:0]     r_pos, n_pos;
    logic [PW-1:0]     lim, diff;

    assign sz = eff_size(i_size);

    always_comb begin
        n_prod = PW'(i_coord[FRAC_W-1:0]) * PW'(sz);
        lim    = PW'(sz - SIZE_W'(1)) << FRAC_W;
        diff   = r_prod - HALF;
        if (r_prod < HALF) begin
            n_pos = '0;
        end else if (diff > lim) begin
            n_pos = lim;
        end else begin
            n_pos = diff;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_pos  <= n_pos;
    end

    assign o_idx  = r_pos[PW-1:FRAC_W];
    assign o_frac = r_pos[FRAC_W-1:0];

endmodule

[rtl/bilinear_texel_sampler_unit.sv]
// Top level of the bilinear texel sampler: texel store, address, weight and blend pipeline.
//
// One beat is taken every cycle; o_busy never rises. A write beat stores one texel; a
// sample beat gives one strobed result, in beat order. The six stages are: axis scale,
// axis clamp, address and weight products, texel store read, per-lane products, lane
// sums. The store is held in two copies that take every write; each copy has two read
// ports, so all four texels of the 2x2 footprint are read in the same cycle. A write
// becomes visible to every sample accepted after it.
`include "assert_macros.svh"
module bilinear_texel_sampler_unit import bts_pkg::*; #(
    parameter int TEX_WORDS       = 65536,
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  logic                  i_req_type,
    input  logic [IN_ADDR_W-1:0]  i_texel_addr,
    input  logic [TEXEL_W-1:0]    i_texel_value,
    input  logic signed [COORD_W-1:0] i_coord_s,
    input  logic signed [COORD_W-1:0] i_coord_t,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [SIZE_W-1:0]     i_cfg_data,
    output logic                  o_strobe,
    output logic [LANE_W-1:0]     o_lane0_value,
    output logic [LANE_W-1:0]     o_lane1_value,
    output logic [LANE_W-1:0]     o_lane2_value,
    output logic [LANE_W-1:0]     o_lane3_value
);

    localparam int AW   = $clog2(TEX_WORDS);
    localparam int F    = COORD_FRAC_BITS;
    localparam int WP_W = 2 * F + 2;
    localparam logic [F:0] ONE_FX = {1'b1, {F{1'b0}}};

    // configuration
    logic [SIZE_W-1:0] r_tex_width, r_tex_height, r_row_pitch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_width  <= SIZE_RESET;
            r_tex_height <= SIZE_RESET;
            r_row_pitch  <= SIZE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_TEX_WIDTH:  r_tex_width  <= i_cfg_data;
                REG_TEX_HEIGHT: r_tex_height <= i_cfg_data;
                REG_ROW_PITCH:  r_row_pitch  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_busy = 1'b0;

    // control chain
    t_ctl n_c0, r_c1, r_c2, r_c3, r_c4, r_c5;
    logic r_strobe;

    always_comb begin
        n_c0.valid  = i_start && !o_busy;
        n_c0.sample = (i_req_type == REQ_SAMPLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1     <= '0;
            r_c2     <= '0;
            r_c3     <= '0;
            r_c4     <= '0;
            r_c5     <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_c1     <= n_c0;
            r_c2     <= r_c1;
            r_c3     <= r_c2;
            r_c4     <= r_c3;
            r_c5     <= r_c4;
            r_strobe <= r_c5.valid && r_c5.sample;
        end
    end

    // write beats ride along to the store stage
    logic [IN_ADDR_W-1:0] r_wa1, r_wa2, r_wa3;
    t_texel               r_wd1, r_wd2, r_wd3;

    always_ff @(posedge i_clk) begin
        r_wa1 <= i_texel_addr;
        r_wd1 <= i_texel_value;
        r_wa2 <= r_wa1;
        r_wd2 <= r_wd1;
        r_wa3 <= r_wa2;
        r_wd3 <= r_wd2;
    end

    // stages 1 and 2: per-axis position
    logic [SIZE_W-1:0] px, py;
    logic [F-1:0]      fx, fy;

    bts_axis #(.FRAC_W(F)) u_axis_s (
        .i_clk   (i_clk),
        .i_coord (i_coord_s),
        .i_size  (r_tex_width),
        .o_idx   (px),
        .o_frac  (fx)
    );

    bts_axis #(.FRAC_W(F)) u_axis_t (
        .i_clk   (i_clk),
        .i_coord (i_coord_t),
        .i_size  (r_tex_height),
        .o_idx   (py),
        .o_frac  (fy)
    );

    // stage 3: base address and tap weights
    logic [F:0]              ox, oy, gx, gy;
    logic [WP_W-1:0]         wp [TAPS];
    logic [ADDR_FULL_W-1:0]  prow, n_base, r_base3;
    t_weight                 n_w [TAPS];
    t_weight                 r_w3 [TAPS];

    always_comb begin
        gx = {1'b0, fx};
        gy = {1'b0, fy};
        ox = ONE_FX - gx;
        oy = ONE_FX - gy;
        wp[0] = WP_W'(ox) * WP_W'(oy);
        wp[1] = WP_W'(gx) * WP_W'(oy);
        wp[2] = WP_W'(ox) * WP_W'(gy);
        wp[3] = WP_W'(gx) * WP_W'(gy);
        for (int k = 0; k < TAPS; k++) begin
            n_w[k] = wp[k][2*F : 2*F-8];
        end
        prow   = ADDR_FULL_W'(py) * ADDR_FULL_W'(r_row_pitch);
        n_base = ADDR_FULL_W'(px) + prow;
    end

    always_ff @(posedge i_clk) begin
        r_base3 <= n_base;
        for (int k = 0; k < TAPS; k++) begin
            r_w3[k] <= n_w[k];
        end
    end

    // stage 4: texel store, two copies with two read ports each
    logic [ADDR_FULL_W-1:0] a_full [TAPS];
    logic [ADDR_FULL_W-1:0] wa_full;
    logic [AW-1:0]          rd_addr [TAPS];
    logic [AW-1:0]          wr_addr;
    logic                   wr_en;

    always_comb begin
        a_full[0] = r_base3;
        a_full[1] = r_base3 + ADDR_FULL_W'(1);
        a_full[2] = r_base3 + ADDR_FULL_W'(r_row_pitch);
        a_full[3] = r_base3 + ADDR_FULL_W'(r_row_pitch) + ADDR_FULL_W'(1);
        for (int k = 0; k < TAPS; k++) begin
            rd_addr[k] = a_full[k][AW-1:0];
        end
        wa_full = ADDR_FULL_W'(r_wa3);
        wr_addr = wa_full[AW-1:0];
        wr_en   = r_c3.valid && !r_c3.sample;
    end

    t_texel mem_a [TEX_WORDS];
    t_texel mem_b [TEX_WORDS];
    t_texel r_rd_a [2];
    t_texel r_rd_b [2];
    t_weight r_w4 [TAPS];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_a[wr_addr] <= r_wd3;
        end
        r_rd_a[0] <= mem_a[rd_addr[0]];
        r_rd_a[1] <= mem_a[rd_addr[1]];
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_b[wr_addr] <= r_wd3;
        end
        r_rd_b[0] <= mem_b[rd_addr[2]];
        r_rd_b[1] <= mem_b[rd_addr[3]];
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < TAPS; k++) begin
            r_w4[k] <= r_w3[k];
        end
    end

    // stage 5: weighted bytes; zero-weight taps are never used
    t_texel             tap_texel [TAPS];
    logic [PRD_W-1:0]   n_prd [LANES][TAPS];
    logic [PRD_W-1:0]   r_prd [LANES][TAPS];

    always_comb begin
        tap_texel[0] = r_rd_a[0];
        tap_texel[1] = r_rd_a[1];
        tap_texel[2] = r_rd_b[0];
        tap_texel[3] = r_rd_b[1];
        for (int k = 0; k < TAPS; k++) begin
            if (r_w4[k] == '0) begin
                tap_texel[k] = '0;
            end
        end
        for (int l = 0; l < LANES; l++) begin
            for (int k = 0; k < TAPS; k++) begin
                n_prd[l][k] = PRD_W'(r_w4[k]) * PRD_W'(tap_texel[k][LANE_W*l +: LANE_W]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < LANES; l++) begin
            for (int k = 0; k < TAPS; k++) begin
                r_prd[l][k] <= n_prd[l][k];
            end
        end
    end

    // stage 6: lane sums, scale and saturate
    logic [ACC_W-1:0]  acc [LANES];
    logic [ACC_W-9:0]  scaled [LANES];
    logic [LANE_W-1:0] n_lane [LANES];
    logic [LANE_W-1:0] r_lane [LANES];

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            acc[l] = ACC_W'(r_prd[l][0]) + ACC_W'(r_prd[l][1])
                   + ACC_W'(r_prd[l][2]) + ACC_W'(r_prd[l][3]);
            scaled[l] = acc[l][ACC_W-1:8];
            n_lane[l] = (scaled[l] > (ACC_W-8)'(255)) ? 8'hFF : scaled[l][LANE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < LANES; l++) begin
            r_lane[l] <= n_lane[l];
        end
    end

    // red/blue swap
    assign o_strobe      = r_strobe;
    assign o_lane0_value = r_lane[2];
    assign o_lane1_value = r_lane[1];
    assign o_lane2_value = r_lane[0];
    assign o_lane3_value = r_lane[3];

    logic [WEIGHT_W+1:0] w4_sum;

    assign w4_sum = (WEIGHT_W+2)'(r_w4[0]) + (WEIGHT_W+2)'(r_w4[1])
                  + (WEIGHT_W+2)'(r_w4[2]) + (WEIGHT_W+2)'(r_w4[3]);

    `ASSERT_NEXT(a_sample_reaches_out, i_clk, i_rst_n, r_c5.valid && r_c5.sample, o_strobe)
    `ASSERT_IMPLIES(a_no_spurious_strobe, i_clk, i_rst_n, o_strobe, $past(r_c4.valid && r_c4.sample, 2))
    `ASSERT_IMPLIES(a_weight_sum, i_clk, i_rst_n, r_c4.valid && r_c4.sample, w4_sum <= (WEIGHT_W+2)'(256))

endmodule
